/* design/assert_macros.svh */
// assertion macros shared by the encoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define AED_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define AED_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* design/aedenc_pkg.sv */
// package: widths, request type and prefix code tables of the delta encoder
`default_nettype none

package aedenc_pkg;

    localparam int SAMPLE_W          = 16;
    localparam int GROUPS            = 15;
    localparam int GRP_W             = 4;
    localparam int VAL_W             = 14;
    localparam int CODE_W            = 26;
    localparam int LEN_W             = 5;
    localparam int PREFIX_W          = 12;
    localparam int DIFF_W            = 17;
    localparam int CLAMP_W           = 15;
    localparam int DIFF_LIMIT        = 16383;
    localparam int COUNT_WIDTH_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF   = 2;

    typedef struct packed {
        logic [VAL_W-1:0] val;
        logic [GRP_W-1:0] grp;
        logic             ovf;
        logic             last;
    } t_item;

    function automatic logic [PREFIX_W-1:0] prefix_bits(input logic [GRP_W-1:0] rank);
        logic [PREFIX_W-1:0] r;
        begin
            unique case (rank)
                4'd0:    r = 12'h000;
                4'd1:    r = 12'h002;
                4'd2:    r = 12'h004;
                4'd3:    r = 12'h006;
                4'd4:    r = 12'h01e;
                4'd5:    r = 12'h07e;
                4'd6:    r = 12'h1fe;
                4'd7:    r = 12'h7fe;
                4'd8:    r = 12'hffe;
                4'd9:    r = 12'h3fe;
                4'd10:   r = 12'h0fe;
                4'd11:   r = 12'h03e;
                4'd12:   r = 12'h00e;
                4'd13:   r = 12'h005;
                4'd14:   r = 12'h003;
                default: r = 12'h000;
            endcase
            return r;
        end
    endfunction

    function automatic logic [GRP_W-1:0] prefix_len(input logic [GRP_W-1:0] rank);
        logic [GRP_W-1:0] r;
        begin
            unique case (rank)
                4'd0:    r = 4'd2;
                4'd1:    r = 4'd3;
                4'd2:    r = 4'd3;
                4'd3:    r = 4'd3;
                4'd4:    r = 4'd5;
                4'd5:    r = 4'd7;
                4'd6:    r = 4'd9;
                4'd7:    r = 4'd11;
                4'd8:    r = 4'd12;
                4'd9:    r = 4'd10;
                4'd10:   r = 4'd8;
                4'd11:   r = 4'd6;
                4'd12:   r = 4'd4;
                4'd13:   r = 4'd3;
                4'd14:   r = 4'd3;
                default: r = 4'd2;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

/* design/adaptive_entropy_delta_encoder.sv */
// Adaptive entropy delta encoder, one prefix code per signed 16-bit sample.
// Input channel: sample and last are taken at an edge with push high and full low.
// Result channel: code, code_len, overflow and last_out hold the oldest result
// while empty is low; it is taken at an edge with pop high.
// Config channel: one register, the dc reference, written when i_cfg_valid is high;
// o_cfg_ready is always high. The first sample of each block is differenced
// against it.
// Path: a pushed request is written into the queue, then moved into the result
// register when that is empty or popped. Throughput: one request per cycle while
// full is low and the receiver pops. The front end takes the delta of the input
// sample to a stored reference; the back end holds a registered loop of group
// count update and leading group compare; a two-entry queue sits between them.
// Reset: dc reference, previous sample, counts and leading group clear; queue and
// result register are empty. The same counts clear after a request with last.
// Receiver stall: the result register holds, the queue fills, then full rises.
`default_nettype none

module adaptive_entropy_delta_encoder #(
    parameter int COUNT_WIDTH = aedenc_pkg::COUNT_WIDTH_DEF,
    parameter int QUEUE_DEPTH = aedenc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic signed [aedenc_pkg::SAMPLE_W-1:0] i_cfg_data,
    input  wire logic                                   push,
    output logic                                        full,
    input  wire logic signed [aedenc_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic                                   i_last,
    output logic                                        empty,
    input  wire logic                                   pop,
    output logic [aedenc_pkg::CODE_W-1:0]               o_code,
    output logic [aedenc_pkg::LEN_W-1:0]                o_code_len,
    output logic                                        o_overflow,
    output logic                                        o_last_out
);
    import aedenc_pkg::*;

    logic  wr;
    t_item wr_item;
    logic  q_empty;
    logic  q_rd;
    t_item q_item;

    aedenc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_full      (full),
        .i_sample    (i_sample),
        .i_last      (i_last),
        .o_wr        (wr),
        .o_item      (wr_item)
    );

    aedenc_queue #(
        .WIDTH ($bits(t_item)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_data  (wr_item),
        .o_full  (full),
        .i_rd    (q_rd),
        .o_empty (q_empty),
        .o_data  (q_item)
    );

    aedenc_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_q_item   (q_item),
        .o_q_rd     (q_rd),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_code     (o_code),
        .o_code_len (o_code_len),
        .o_overflow (o_overflow),
        .o_last_out (o_last_out)
    );

endmodule

`default_nettype wire

/* design/aedenc_front.sv */
// front end: delta against dc reference or previous sample, clamp, group and value bits
`default_nettype none

module aedenc_front (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic signed [aedenc_pkg::SAMPLE_W-1:0] i_cfg_data,
    input  wire logic                               i_push,
    input  wire logic                               i_full,
    input  wire logic signed [aedenc_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic                               i_last,
    output logic                                    o_wr,
    output aedenc_pkg::t_item                       o_item
);
    import aedenc_pkg::*;

    logic signed [SAMPLE_W-1:0] r_dc, n_dc;
    logic signed [SAMPLE_W-1:0] r_prev, n_prev;
    logic                       r_block_start, n_block_start;

    logic signed [SAMPLE_W-1:0] ref_s;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [CLAMP_W-1:0]  diff_c;
    logic signed [CLAMP_W-1:0]  val_full;
    logic [CLAMP_W-1:0]         mag_full;
    logic [VAL_W-1:0]           mag;
    logic [VAL_W-1:0]           mask;
    logic [GRP_W-1:0]           grp;
    logic                       ovf;
    logic                       accept;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_push && !i_full;

    always_comb begin
        ref_s = r_block_start ? r_dc : r_prev;
        diff  = DIFF_W'(i_sample) - DIFF_W'(ref_s);
        ovf   = 1'b0;
        if (diff > DIFF_W'(DIFF_LIMIT)) begin
            diff_c = CLAMP_W'(DIFF_LIMIT);
            ovf    = 1'b1;
        end else if (diff < -DIFF_W'(DIFF_LIMIT)) begin
            diff_c = -CLAMP_W'(DIFF_LIMIT);
            ovf    = 1'b1;
        end else begin
            diff_c = diff[CLAMP_W-1:0];
        end
        mag_full = diff_c[CLAMP_W-1] ? CLAMP_W'(-diff_c) : diff_c;
        mag      = mag_full[VAL_W-1:0];
        grp      = '0;
        for (int i = 0; i < VAL_W; i++) begin
            if (mag[i]) begin
                grp = GRP_W'(i + 1);
            end
        end
        mask     = VAL_W'((CLAMP_W'(1) << grp) - CLAMP_W'(1));
        val_full = (diff_c > 0) ? diff_c : diff_c - CLAMP_W'(1);
    end

    always_comb begin
        o_wr        = accept;
        o_item.val  = val_full[VAL_W-1:0] & mask;
        o_item.grp  = grp;
        o_item.ovf  = ovf;
        o_item.last = i_last;
    end

    always_comb begin
        n_dc          = (i_cfg_valid && o_cfg_ready) ? i_cfg_data : r_dc;
        n_prev        = accept ? i_sample : r_prev;
        n_block_start = accept ? i_last : r_block_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc          <= '0;
            r_prev        <= '0;
            r_block_start <= 1'b1;
        end else begin
            r_dc          <= n_dc;
            r_prev        <= n_prev;
            r_block_start <= n_block_start;
        end
    end

endmodule

`default_nettype wire

/* design/aedenc_queue.sv */
// short register queue between front and back end
`default_nettype none
`include "assert_macros.svh"

module aedenc_queue #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_rd,
    output logic                  o_empty,
    output logic [WIDTH-1:0]      o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_wr;
    logic             do_rd;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_wr) begin
            n_wp = (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
        end
        if (do_rd) begin
            n_rp = (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
        end
        if (do_wr && !do_rd) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_rd && !do_wr) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    `AED_ASSERT(a_cnt_bound, r_cnt <= CNT_W'(DEPTH), "queue count above depth")
    `AED_ASSERT(a_no_write_when_full, o_full |-> !i_wr, "request written into full queue")
    `AED_ASSERT(a_no_read_when_empty, o_empty |-> !i_rd, "request read from empty queue")

endmodule

`default_nettype wire

/* design/aedenc_back.sv */
// back end: rank against leading group, prefix lookup, group count update
`default_nettype none
`include "assert_macros.svh"

module aedenc_back #(
    parameter int COUNT_WIDTH = aedenc_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_q_empty,
    input  wire aedenc_pkg::t_item             i_q_item,
    output logic                               o_q_rd,
    input  wire logic                          i_pop,
    output logic                               o_empty,
    output logic [aedenc_pkg::CODE_W-1:0]      o_code,
    output logic [aedenc_pkg::LEN_W-1:0]       o_code_len,
    output logic                               o_overflow,
    output logic                               o_last_out
);
    import aedenc_pkg::*;

    logic [COUNT_WIDTH-1:0] r_counts [GROUPS];
    logic [COUNT_WIDTH-1:0] n_counts [GROUPS];
    logic [GRP_W-1:0]       r_lead, n_lead;
    logic [COUNT_WIDTH-1:0] r_lead_cnt, n_lead_cnt;
    logic                   r_valid, n_valid;
    logic [CODE_W-1:0]      r_code, n_code;
    logic [LEN_W-1:0]       r_len, n_len;
    logic                   r_ovf, n_ovf;
    logic                   r_last, n_last;

    logic                   take;
    logic [GRP_W:0]         rank_d;
    logic [GRP_W-1:0]       rank;
    logic [COUNT_WIDTH-1:0] cur_cnt;
    logic [COUNT_WIDTH-1:0] new_cnt;

    assign take       = !i_q_empty && (!r_valid || i_pop);
    assign o_q_rd     = take;
    assign o_empty    = !r_valid;
    assign o_code     = r_code;
    assign o_code_len = r_len;
    assign o_overflow = r_ovf;
    assign o_last_out = r_last;

    always_comb begin
        rank_d  = {1'b0, i_q_item.grp} - {1'b0, r_lead};
        rank    = rank_d[GRP_W] ? GRP_W'(rank_d + (GRP_W+1)'(GROUPS)) : rank_d[GRP_W-1:0];
        n_code  = (CODE_W'(prefix_bits(rank)) << i_q_item.grp) | CODE_W'(i_q_item.val);
        n_len   = LEN_W'(prefix_len(rank)) + LEN_W'(i_q_item.grp);
        n_ovf   = i_q_item.ovf;
        n_last  = i_q_item.last;
        n_valid = take || (r_valid && !i_pop);
    end

    always_comb begin
        cur_cnt    = r_counts[i_q_item.grp];
        new_cnt    = (&cur_cnt) ? cur_cnt : cur_cnt + COUNT_WIDTH'(1);
        n_counts   = r_counts;
        n_lead     = r_lead;
        n_lead_cnt = r_lead_cnt;
        if (take) begin
            if (i_q_item.last) begin
                for (int i = 0; i < GROUPS; i++) begin
                    n_counts[i] = '0;
                end
                n_lead     = '0;
                n_lead_cnt = '0;
            end else begin
                n_counts[i_q_item.grp] = new_cnt;
                if (i_q_item.grp == r_lead) begin
                    n_lead_cnt = new_cnt;
                end else if (new_cnt > r_lead_cnt) begin
                    n_lead     = i_q_item.grp;
                    n_lead_cnt = new_cnt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < GROUPS; i++) begin
                r_counts[i] <= '0;
            end
            r_lead     <= '0;
            r_lead_cnt <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_counts   <= n_counts;
            r_lead     <= n_lead;
            r_lead_cnt <= n_lead_cnt;
            r_valid    <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_code <= n_code;
            r_len  <= n_len;
            r_ovf  <= n_ovf;
            r_last <= n_last;
        end
    end

    `AED_ASSERT(a_lead_cnt_tracks, r_lead_cnt == r_counts[r_lead], "leader count out of step")
    `AED_ASSERT(a_lead_range, r_lead < GRP_W'(GROUPS), "leading group out of range")
    `AED_ASSERT(a_hold_on_stall, (r_valid && !i_pop) |=> (r_valid && $stable(r_code)), "result lost while stalled")

endmodule

`default_nettype wire

/* tb/sv/aed_tb_pkg.sv */
// code tables, predictor and result checker for the delta encoder testbench
package aed_tb_pkg;
    import aedenc_pkg::*;

    localparam logic [PREFIX_W-1:0] RANK_PREFIX [GROUPS] = '{
        12'h000, 12'h002, 12'h004, 12'h006, 12'h01e, 12'h07e, 12'h1fe, 12'h7fe,
        12'hffe, 12'h3fe, 12'h0fe, 12'h03e, 12'h00e, 12'h005, 12'h003
    };
    localparam int RANK_PREFIX_LEN [GROUPS] = '{
        2, 3, 3, 3, 5, 7, 9, 11, 12, 10, 8, 6, 4, 3, 3
    };
    localparam int unsigned COUNT_MAX = (1 << COUNT_WIDTH_DEF) - 1;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  code_len;
        logic              overflow;
        logic              last_out;
    } t_coded;

    class code_checker;
        logic signed [SAMPLE_W-1:0] dc_ref;
        logic signed [SAMPLE_W-1:0] prev_sample;
        bit                         at_block_start;
        int unsigned                group_hits [GROUPS];
        int                         leader;
        t_coded                     pending_codes [$];
        int                         errors;

        function new();
            dc_ref = '0;
            prev_sample = '0;
            errors = 0;
            restart_block();
        endfunction

        function void restart_block();
            foreach (group_hits[i]) group_hits[i] = 0;
            leader = 0;
            at_block_start = 1'b1;
        endfunction

        function logic signed [SAMPLE_W-1:0] next_reference();
            return at_block_start ? dc_ref : prev_sample;
        endfunction

        function void encode_sample(input logic signed [SAMPLE_W-1:0] s, input logic l);
            int          diff;
            int          mag;
            int          grp;
            int          rank;
            int unsigned val;
            t_coded      c;
            diff = int'(s) - int'(next_reference());
            c.overflow = 1'b0;
            if (diff > DIFF_LIMIT) begin
                diff = DIFF_LIMIT;
                c.overflow = 1'b1;
            end
            if (diff < -DIFF_LIMIT) begin
                diff = -DIFF_LIMIT;
                c.overflow = 1'b1;
            end
            mag = (diff < 0) ? -diff : diff;
            grp = 0;
            while (mag != 0) begin
                mag = mag >> 1;
                grp++;
            end
            rank = (grp + GROUPS - leader) % GROUPS;
            val = (diff > 0) ? diff : diff + (1 << grp) - 1;
            val = val & ((1 << grp) - 1);
            c.code = (CODE_W'(RANK_PREFIX[rank]) << grp) | CODE_W'(val);
            c.code_len = LEN_W'(RANK_PREFIX_LEN[rank] + grp);
            c.last_out = l;
            pending_codes.push_back(c);
            // leader is chosen after ranking this request
            if (group_hits[grp] < COUNT_MAX) group_hits[grp]++;
            if (group_hits[grp] > group_hits[leader]) leader = grp;
            prev_sample = s;
            at_block_start = 1'b0;
            if (l) restart_block();
        endfunction

        function void check_code(input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] code_len,
                                 input logic overflow, input logic last_out);
            t_coded want;
            if (pending_codes.size() == 0) begin
                $error("unexpected result: code %h, code_len %0d", code, code_len);
                errors++;
                return;
            end
            want = pending_codes.pop_front();
            if (code !== want.code) begin
                $error("code: expected %h, got %h", want.code, code);
                errors++;
            end
            if (code_len !== want.code_len) begin
                $error("code_len: expected %0d, got %0d", want.code_len, code_len);
                errors++;
            end
            if (overflow !== want.overflow) begin
                $error("overflow: expected %0b, got %0b", want.overflow, overflow);
                errors++;
            end
            if (last_out !== want.last_out) begin
                $error("last_out: expected %0b, got %0b", want.last_out, last_out);
                errors++;
            end
        endfunction
    endclass
endpackage

/* tb/sv/tb_adaptive_entropy_delta_encoder.sv */
// top level testbench of the adaptive entropy delta encoder
module tb_adaptive_entropy_delta_encoder;
    timeunit 1ns;
    timeprecision 1ps;
    import aedenc_pkg::*;
    import aed_tb_pkg::*;

    localparam int STALL_LIMIT      = 4000;
    localparam int RANDOM_PER_PHASE = 350;
    localparam int SAT_RUN          = 20;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic signed [SAMPLE_W-1:0] cfg_data = '0;
    logic                       push = 1'b0;
    logic                       full;
    logic signed [SAMPLE_W-1:0] sample_in = '0;
    logic                       last_in = 1'b0;
    logic                       empty;
    logic                       pop = 1'b0;
    logic [CODE_W-1:0]          code_out;
    logic [LEN_W-1:0]           code_len_out;
    logic                       overflow_out;
    logic                       last_out;

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          quiet_cycles = 0;
    code_checker codes = new();

    adaptive_entropy_delta_encoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .push        (push),
        .full        (full),
        .i_sample    (sample_in),
        .i_last      (last_in),
        .empty       (empty),
        .pop         (pop),
        .o_code      (code_out),
        .o_code_len  (code_len_out),
        .o_overflow  (overflow_out),
        .o_last_out  (last_out)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            codes.check_code(code_out, code_len_out, overflow_out, last_out);
        end
    end

    // nothing moving on any channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_dc(input logic signed [SAMPLE_W-1:0] v);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge i_clk); while (!cfg_ready);
        codes.dc_ref = v;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic l);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        sample_in <= s;
        last_in <= l;
        do @(posedge i_clk); while (full);
        codes.encode_sample(s, l);
    endtask

    task automatic settle();
        @(negedge i_clk);
        push <= 1'b0;
        while (codes.pending_codes.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // deltas often from one favored group per block so the leader moves
    task automatic send_random(input int n);
        int                         kind;
        int                         g;
        int                         d;
        int                         fav;
        logic                       l;
        logic signed [SAMPLE_W-1:0] s;
        fav = $urandom_range(14);
        repeat (n) begin
            kind = $urandom_range(99);
            if (kind < 15) begin
                s = SAMPLE_W'($urandom);
            end else begin
                g = (kind < 60) ? fav : $urandom_range(14);
                d = (g == 0) ? 0 : int'($urandom_range((1 << g) - 1, 1 << (g - 1)));
                if ($urandom_range(1)) d = -d;
                s = SAMPLE_W'(int'(codes.next_reference()) + d);
            end
            l = ($urandom_range(39) == 0);
            send_sample(s, l);
            if (l) fav = $urandom_range(14);
        end
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // dc value at its reset value and at both extremes, delta limits and clamping
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd16383, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(-16'sd16384, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd32767, 1'b0);
        send_sample(-16'sd32768, 1'b0);
        send_sample(-16'sd32768, 1'b0);
        send_sample(-16'sd32767, 1'b0);
        send_sample(-16'sd32768, 1'b1);
        settle();
        write_dc(16'sd32767);
        send_sample(16'sd32767, 1'b0);
        send_sample(16'sd32736, 1'b0);
        send_sample(16'sd32705, 1'b0);
        send_sample(16'sd32674, 1'b0);
        send_sample(16'sd32675, 1'b0);
        send_sample(16'sd32674, 1'b1);
        send_sample(-16'sd1, 1'b1);
        settle();
        write_dc(-16'sd32768);
        send_sample(16'sd32767, 1'b0);
        send_sample(16'sd32766, 1'b0);
        send_sample(16'sd30000, 1'b0);
        send_sample(16'sd30000, 1'b1);
        settle();

        // long run in group zero, then group one must stay behind
        repeat (SAT_RUN) send_sample(-16'sd32768, 1'b0);
        repeat (4) begin
            send_sample(-16'sd32767, 1'b0);
            send_sample(-16'sd32768, 1'b0);
        end
        send_sample(-16'sd32768, 1'b1);
        settle();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    write_dc(SAMPLE_W'($urandom));
                end
                1: begin
                    send_idle_pct = 62;
                    recv_stall_pct = 0;
                    write_dc(16'sd32767);
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 62;
                    write_dc(-16'sd32768);
                end
                default: begin
                    send_idle_pct = 16;
                    recv_stall_pct = 16;
                    write_dc(16'sd0);
                end
            endcase
            send_random(RANDOM_PER_PHASE);
            settle();
        end

        repeat (8) @(posedge i_clk);
        if (codes.errors == 0 && codes.pending_codes.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
